@@ design/amk_pkg.sv @@
package amk_pkg;

  localparam int CFG_DATA_W = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int MAX_SYMS = 7;

  localparam logic [CFG_INDEX_W-1:0] REG_DOT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DASH = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_WORD_GAP = 2'd2;

  localparam logic [CFG_DATA_W-1:0] DOT_RESET = 16'd100;
  localparam logic [CFG_DATA_W-1:0] DASH_RESET = 16'd300;
  localparam logic [CFG_DATA_W-1:0] WORD_GAP_RESET = 16'd700;

  typedef logic [$clog2(MAX_SYMS+1)-1:0] sym_count_t;

  typedef struct packed {
    logic gap;
    sym_count_t len;
    logic [MAX_SYMS-1:0] bits;
  } code_t;

  typedef struct packed {
    logic load;
    logic emit_mark;
    logic emit_space;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic slot_free;
    logic last_sym;
  } stat_t;

  function automatic code_t morse_code(input logic [7:0] ch);
    logic [7:0] c;
    sym_count_t len;
    logic [MAX_SYMS-1:0] raw;
    logic gap;
    code_t r;
    c = (ch >= 8'h41 && ch <= 8'h5A) ? (ch | 8'h20) : ch;
    gap = 1'b0;
    case (c)
      "a": {len, raw} = {3'd2, 7'b01};
      "b": {len, raw} = {3'd4, 7'b1000};
      "c": {len, raw} = {3'd4, 7'b1010};
      "d": {len, raw} = {3'd3, 7'b100};
      "e": {len, raw} = {3'd1, 7'b0};
      "f": {len, raw} = {3'd4, 7'b0010};
      "g": {len, raw} = {3'd3, 7'b110};
      "h": {len, raw} = {3'd4, 7'b0000};
      "i": {len, raw} = {3'd2, 7'b00};
      "j": {len, raw} = {3'd4, 7'b0111};
      "k": {len, raw} = {3'd3, 7'b101};
      "l": {len, raw} = {3'd4, 7'b0100};
      "m": {len, raw} = {3'd2, 7'b11};
      "n": {len, raw} = {3'd2, 7'b10};
      "o": {len, raw} = {3'd3, 7'b111};
      "p": {len, raw} = {3'd4, 7'b0110};
      "q": {len, raw} = {3'd4, 7'b1101};
      "r": {len, raw} = {3'd3, 7'b010};
      "s": {len, raw} = {3'd3, 7'b000};
      "t": {len, raw} = {3'd1, 7'b1};
      "u": {len, raw} = {3'd3, 7'b001};
      "v": {len, raw} = {3'd4, 7'b0001};
      "w": {len, raw} = {3'd3, 7'b011};
      "x": {len, raw} = {3'd4, 7'b1001};
      "y": {len, raw} = {3'd4, 7'b1011};
      "z": {len, raw} = {3'd4, 7'b1100};
      "0": {len, raw} = {3'd5, 7'b11111};
      "1": {len, raw} = {3'd5, 7'b01111};
      "2": {len, raw} = {3'd5, 7'b00111};
      "3": {len, raw} = {3'd5, 7'b00011};
      "4": {len, raw} = {3'd5, 7'b00001};
      "5": {len, raw} = {3'd5, 7'b00000};
      "6": {len, raw} = {3'd5, 7'b10000};
      "7": {len, raw} = {3'd5, 7'b11000};
      "8": {len, raw} = {3'd5, 7'b11100};
      "9": {len, raw} = {3'd5, 7'b11110};
      8'h20, 8'h09: begin
        {len, raw} = {3'd1, 7'b0};
        gap = 1'b1;
      end
      ".": {len, raw} = {3'd6, 7'b010101};
      ",": {len, raw} = {3'd6, 7'b110011};
      "?": {len, raw} = {3'd6, 7'b001100};
      8'h27: {len, raw} = {3'd6, 7'b011110};
      "!": {len, raw} = {3'd6, 7'b101011};
      "/": {len, raw} = {3'd5, 7'b10010};
      "(": {len, raw} = {3'd5, 7'b10110};
      ")": {len, raw} = {3'd6, 7'b101101};
      "&": {len, raw} = {3'd5, 7'b01000};
      ":": {len, raw} = {3'd6, 7'b111000};
      ";": {len, raw} = {3'd6, 7'b101010};
      "=": {len, raw} = {3'd5, 7'b10001};
      "+": {len, raw} = {3'd5, 7'b01010};
      "-": {len, raw} = {3'd6, 7'b100001};
      "_": {len, raw} = {3'd6, 7'b001101};
      8'h22: {len, raw} = {3'd6, 7'b010010};
      "$": {len, raw} = {3'd7, 7'b0001001};
      "@": {len, raw} = {3'd6, 7'b011010};
      default: {len, raw} = {3'd0, 7'b0};
    endcase
    r.gap = gap;
    r.len = len;
    r.bits = raw << (3'd7 - len);
    return r;
  endfunction

endpackage

@@ design/amk_ifs.sv @@
interface amk_in_if;
  logic valid;
  logic ready;
  logic [7:0] char_code;
  modport source (output valid, output char_code, input ready);
  modport sink (input valid, input char_code, output ready);
endinterface

interface amk_out_if #(parameter int HOLD_WIDTH = 16);
  logic valid;
  logic ready;
  logic lamp_on;
  logic [HOLD_WIDTH-1:0] hold_ticks;
  logic last_of_char;
  modport source (output valid, output lamp_on, output hold_ticks, output last_of_char,
                  input ready);
  modport sink (input valid, input lamp_on, input hold_ticks, input last_of_char,
                output ready);
endinterface

interface amk_cfg_if;
  logic valid;
  logic ready;
  logic [1:0] index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ design/amk_ctrl.sv @@
module amk_ctrl
  import amk_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MARK = 2'd1;
  localparam logic [1:0] S_SPACE = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        cmd.load = in_valid;
        if (in_valid && !stat.empty) state_next = S_MARK;
      end
      S_MARK: begin
        cmd.emit_mark = stat.slot_free;
        if (stat.slot_free) state_next = S_SPACE;
      end
      S_SPACE: begin
        cmd.emit_space = stat.slot_free;
        if (stat.slot_free) state_next = stat.last_sym ? S_IDLE : S_MARK;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  a_mark_then_space: assert property (@(posedge clk) disable iff (rst)
    (state == S_MARK && stat.slot_free) |=> (state == S_SPACE))
    else $error("mark not followed by space");

  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_SPACE && stat.slot_free && stat.last_sym) |=> in_ready)
    else $error("character end did not return to idle");

  a_emit_needs_slot: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_mark || cmd.emit_space) |-> stat.slot_free)
    else $error("result emitted over a pending one");

endmodule

@@ design/amk_dp.sv @@
module amk_dp
  import amk_pkg::*;
#(
  parameter int HOLD_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  char_code,
  input  cmd_t        cmd,
  output stat_t       stat,
  amk_cfg_if.sink     cfg,
  amk_out_if.source   sym
);

  logic [CFG_DATA_W-1:0] dot_ticks;
  logic [CFG_DATA_W-1:0] dash_ticks;
  logic [CFG_DATA_W-1:0] word_gap_ticks;

  code_t               code;
  logic [MAX_SYMS-1:0] pat;
  sym_count_t          rem;
  logic                gap;

  logic                  out_valid;
  logic                  out_lamp;
  logic [HOLD_WIDTH-1:0] out_hold;
  logic                  out_last;

  logic [CFG_DATA_W-1:0] sel;
  logic [HOLD_WIDTH-1:0] fit;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dot_ticks <= DOT_RESET;
      dash_ticks <= DASH_RESET;
      word_gap_ticks <= WORD_GAP_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_DOT: dot_ticks <= cfg.data;
        REG_DASH: dash_ticks <= cfg.data;
        REG_WORD_GAP: word_gap_ticks <= cfg.data;
        default: ;
      endcase
    end
  end

  assign code = morse_code(char_code);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pat <= code.bits;
      rem <= code.len;
      gap <= code.gap;
    end else if (cmd.emit_space) begin
      pat <= {pat[MAX_SYMS-2:0], 1'b0};
      rem <= rem - 3'd1;
    end
  end

  always_comb begin
    if (cmd.emit_space) sel = dot_ticks;
    else if (gap) sel = word_gap_ticks;
    else if (pat[MAX_SYMS-1]) sel = dash_ticks;
    else sel = dot_ticks;
  end

  if (HOLD_WIDTH > CFG_DATA_W) begin : g_wide
    assign fit = {{(HOLD_WIDTH-CFG_DATA_W){1'b0}}, sel};
  end else if (HOLD_WIDTH == CFG_DATA_W) begin : g_same
    assign fit = sel;
  end else begin : g_narrow
    assign fit = (|sel[CFG_DATA_W-1:HOLD_WIDTH]) ? '1 : sel[HOLD_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.emit_mark || cmd.emit_space) out_valid <= 1'b1;
    else if (sym.ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_mark || cmd.emit_space) begin
      out_lamp <= cmd.emit_mark && !gap;
      out_hold <= fit;
      out_last <= cmd.emit_space && (rem == 3'd1);
    end
  end

  assign stat.empty = (code.len == 3'd0);
  assign stat.slot_free = !out_valid || sym.ready;
  assign stat.last_sym = (rem == 3'd1);

  assign sym.valid = out_valid;
  assign sym.lamp_on = out_lamp;
  assign sym.hold_ticks = out_hold;
  assign sym.last_of_char = out_last;

endmodule

@@ design/ascii_morse_keyer.sv @@
// The request loads the pattern register; the first result is registered
// from it in the mark state. One result every cycle while the output accepts,
// two per symbol, for a character of n symbols (n up to 7); an unsupported
// byte yields none. Stalls hold the controller; the result register paces it.
// Reset (rst, synchronous): clears the controller and the result valid and
// reloads the timing registers with 100, 300 and 700.
module ascii_morse_keyer
  import amk_pkg::*;
#(
  parameter int HOLD_WIDTH = 16
) (
  input  logic      clk,
  input  logic      rst,
  amk_in_if.sink    chr,
  amk_out_if.source sym,
  amk_cfg_if.sink   cfg
);

  cmd_t  cmd;
  stat_t stat;

  amk_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (chr.valid),
    .in_ready (chr.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  amk_dp #(
    .HOLD_WIDTH (HOLD_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .char_code (chr.char_code),
    .cmd       (cmd),
    .stat      (stat),
    .cfg       (cfg),
    .sym       (sym)
  );

endmodule
